[src/hcb_pkg.sv]
// hcb_pkg: sizes, widths and the shared sample type for the Huffman code builder.
// No dependencies.
`default_nettype none
package hcb_pkg;
	localparam int MAX_SYMBOLS = 32;
	localparam int WEIGHT_BITS = 16;
	localparam int NODE_COUNT  = 2 * MAX_SYMBOLS - 1;
	localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
	localparam int SIDX_W      = $clog2(MAX_SYMBOLS);
	localparam int IDX_W       = $clog2(NODE_COUNT);
	localparam int NCNT_W      = $clog2(NODE_COUNT + 1);
	localparam int SUM_W       = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
	localparam int WIN_W       = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
	localparam int CODE_W      = 31;
	localparam int LEN_W       = 5;
	localparam int NCODE_W     = CODE_W + LEN_W;

	// one sample from the scan pipe: valid, live flag and node index
	typedef struct packed {
		logic             vld;
		logic             live;
		logic [IDX_W-1:0] idx;
	} hcb_sample_t;
endpackage
`default_nettype wire

[src/huffman_code_builder_unit.sv]
// huffman_code_builder_unit: top level of the Huffman code builder.
// Depends on hcb_pkg, hcb_ram, hcb_min_unit.
`default_nettype none
// Loads (symbol, weight) items one per cycle until an item with tlast, then
// builds a Huffman tree and emits one code per loaded symbol in ascending
// symbol order, tlast on the final code, tuser set when items beyond
// MAX_SYMBOLS were dropped. Loading runs at one item per cycle. After the last
// item s_tready stays low while the block works: each merge costs two scans of
// the node weight RAM through the single compare unit; the code walk steps
// each internal node through a read, a left and a right state; the output pass
// tests every (symbol value, leaf) pair with a read and a compare state through
// the symbol RAM read port, ending at the last code, and an output stall holds
// it. One leaf alone gets code length 0.
module huffman_code_builder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // symbol[7:0], weight[23:8]
	input  wire logic        s_tlast,   // final_entry
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [47:0] m_tdata,   // out_symbol[7:0], code_bits[38:8], code_length[43:39]
	output logic             m_tuser,   // dropped_some
	output logic             m_tlast    // last_code
);
	localparam int CNT_W   = hcb_pkg::CNT_W;
	localparam int SIDX_W  = hcb_pkg::SIDX_W;
	localparam int IDX_W   = hcb_pkg::IDX_W;
	localparam int NCNT_W  = hcb_pkg::NCNT_W;
	localparam int SUM_W   = hcb_pkg::SUM_W;
	localparam int CODE_W  = hcb_pkg::CODE_W;
	localparam int LEN_W   = hcb_pkg::LEN_W;
	localparam int NCODE_W = hcb_pkg::NCODE_W;
	localparam int NODES   = hcb_pkg::NODE_COUNT;

	typedef enum logic [2:0] {
		ST_LOAD, ST_SCAN, ST_TAKE, ST_WALK_RD, ST_WALK_L, ST_WALK_R, ST_EMIT_RD, ST_EMIT_CMP
	} state_t;

	state_t                       state_q;
	logic [CNT_W-1:0]             cnt_q, n_q, emitted_q;
	logic                         ovf_q, single_q, second_q;
	logic [hcb_pkg::NODE_COUNT-1:0] live_q;
	logic [NCNT_W-1:0]            next_q, idx_q;
	logic [IDX_W-1:0]             a_idx_q, root_q, node_q, r_idx_q;
	logic [SUM_W-1:0]             a_wgt_q;
	logic [CODE_W-1:0]            pc_q;
	logic [LEN_W-1:0]             len_q;
	logic [SIDX_W-1:0]            i_q;
	logic [7:0]                   s_q;
	logic                         m_vld_q, m_last_q, m_drop_q;
	logic [7:0]                   m_sym_q;
	logic [CODE_W-1:0]            m_code_q;
	logic [LEN_W-1:0]             m_len_q;

	// scan pipe
	logic                         rd_vld_s1;
	logic [IDX_W-1:0]             rd_idx_s1;
	hcb_pkg::hcb_sample_t         smp;
	logic                         best_vld;
	logic [IDX_W-1:0]             best_idx;
	logic [SUM_W-1:0]             best_wgt;

	// RAM ports
	logic                         sym_we;
	logic [SIDX_W-1:0]            sym_ra;
	logic [7:0]                   sym_rd;
	logic                         wgt_we;
	logic [IDX_W-1:0]             wgt_wa;
	logic [SUM_W-1:0]             wgt_wd, wgt_rd;
	logic                         kid_we;
	logic [2*IDX_W-1:0]           kid_rd;
	logic                         nc_we;
	logic [IDX_W-1:0]             nc_wa, nc_ra;
	logic [NCODE_W-1:0]           nc_wd, nc_rd;

	logic                         in_acc, full, scan_end, m_free, match, last_pair, at_root;
	logic                         emit_now;
	logic [CNT_W-1:0]             n_new;
	logic [NCNT_W:0]              next_p2, n_x2;
	logic [CODE_W-1:0]            pc;
	logic [LEN_W-1:0]             plen, len_n;

	assign in_acc   = s_tvalid && s_tready;
	assign full     = (cnt_q == CNT_W'(hcb_pkg::MAX_SYMBOLS));
	assign n_new    = full ? cnt_q : cnt_q + CNT_W'(1);
	assign scan_end = (idx_q == next_q) && !rd_vld_s1;
	assign next_p2  = (NCNT_W+1)'(next_q) + (NCNT_W+1)'(2);
	assign n_x2     = (NCNT_W+1)'({n_q, 1'b0});
	assign m_free   = !m_vld_q || m_tready;
	assign match    = (sym_rd == s_q);
	assign last_pair = (i_q == SIDX_W'(n_q - CNT_W'(1)));
	assign emit_now = (state_q == ST_EMIT_CMP) && match && m_free;

	// walk: the root starts from an empty code
	assign at_root = (node_q == root_q);
	assign pc      = at_root ? '0 : nc_rd[CODE_W-1:0];
	assign plen    = at_root ? '0 : nc_rd[NCODE_W-1:CODE_W];
	assign len_n   = (plen == LEN_W'(31)) ? plen : plen + LEN_W'(1);

	// write port muxes
	assign sym_we = in_acc && !full;
	assign wgt_we = sym_we || (state_q == ST_TAKE && second_q);
	assign kid_we = (state_q == ST_TAKE) && second_q;
	assign wgt_wa = (state_q == ST_LOAD) ? IDX_W'(cnt_q) : next_q[IDX_W-1:0];
	assign wgt_wd = (state_q == ST_LOAD)
		? SUM_W'(s_tdata[8 +: hcb_pkg::WIN_W]) : a_wgt_q + best_wgt;
	assign nc_we  = (state_q == ST_WALK_L) || (state_q == ST_WALK_R);
	assign nc_wa  = (state_q == ST_WALK_L) ? kid_rd[IDX_W-1:0] : r_idx_q;
	assign nc_wd  = (state_q == ST_WALK_L) ? {len_n, pc[CODE_W-2:0], 1'b0}
		: {len_q, pc_q[CODE_W-2:0], 1'b1};
	assign nc_ra  = (state_q == ST_EMIT_RD || state_q == ST_EMIT_CMP) ? IDX_W'(i_q) : node_q;
	assign sym_ra = i_q;

	hcb_ram #(.WIDTH(8), .DEPTH(hcb_pkg::MAX_SYMBOLS)) u_sym (
		.clk, .wr_en(sym_we), .wr_addr(cnt_q[SIDX_W-1:0]), .wr_data(s_tdata[7:0]),
		.rd_addr(sym_ra), .rd_data(sym_rd)
	);
	hcb_ram #(.WIDTH(SUM_W), .DEPTH(hcb_pkg::NODE_COUNT)) u_wgt (
		.clk, .wr_en(wgt_we), .wr_addr(wgt_wa), .wr_data(wgt_wd),
		.rd_addr(idx_q[IDX_W-1:0]), .rd_data(wgt_rd)
	);
	// children: right in the upper half, left in the lower
	hcb_ram #(.WIDTH(2*IDX_W), .DEPTH(hcb_pkg::NODE_COUNT)) u_kid (
		.clk, .wr_en(kid_we), .wr_addr(next_q[IDX_W-1:0]), .wr_data({best_idx, a_idx_q}),
		.rd_addr(node_q), .rd_data(kid_rd)
	);
	// per-node code: {length, bits}
	hcb_ram #(.WIDTH(NCODE_W), .DEPTH(hcb_pkg::NODE_COUNT)) u_ncode (
		.clk, .wr_en(nc_we), .wr_addr(nc_wa), .wr_data(nc_wd),
		.rd_addr(nc_ra), .rd_data(nc_rd)
	);

	assign smp.vld  = rd_vld_s1;
	assign smp.idx  = rd_idx_s1;
	assign smp.live = live_q[rd_idx_s1];

	hcb_min_unit u_min (
		.clk, .arst_n, .clr(state_q != ST_SCAN), .smp, .wgt(wgt_rd),
		.best_vld_q(best_vld), .best_idx_q(best_idx), .best_wgt_q(best_wgt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			live_q    <= '0;
			rd_vld_s1 <= 1'b0;
			m_vld_q   <= 1'b0;
			second_q  <= 1'b0;
		end else begin
			if (emit_now) begin
				m_vld_q <= 1'b1;
			end else if (m_tready) begin
				m_vld_q <= 1'b0;
			end
			rd_vld_s1 <= (state_q == ST_SCAN) && (idx_q != next_q);
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							live_q[cnt_q[IDX_W-1:0]] <= 1'b1;
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (s_tlast) begin
							n_q       <= n_new;
							next_q    <= NCNT_W'(n_new);
							idx_q     <= '0;
							second_q  <= 1'b0;
							single_q  <= (n_new == CNT_W'(1));
							s_q       <= '0;
							i_q       <= '0;
							emitted_q <= '0;
							state_q   <= (n_new == CNT_W'(1)) ? ST_EMIT_RD : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (idx_q != next_q) begin
						idx_q <= idx_q + NCNT_W'(1);
					end
					if (scan_end) begin
						state_q <= ST_TAKE;
					end
				end
				ST_TAKE: begin
					idx_q <= '0;
					if (!second_q) begin
						live_q[best_idx] <= 1'b0;
						a_idx_q  <= best_idx;
						a_wgt_q  <= best_wgt;
						second_q <= 1'b1;
						state_q  <= ST_SCAN;
					end else begin
						// retire the second node, bring in the merged one
						live_q   <= (live_q & ~(NODES'(1) << best_idx))
							| (NODES'(1) << next_q[IDX_W-1:0]);
						next_q   <= next_q + NCNT_W'(1);
						second_q <= 1'b0;
						if (next_p2 < n_x2) begin
							state_q <= ST_SCAN;
						end else begin
							root_q  <= next_q[IDX_W-1:0];
							node_q  <= next_q[IDX_W-1:0];
							state_q <= ST_WALK_RD;
						end
					end
				end
				ST_WALK_RD: begin
					state_q <= ST_WALK_L;
				end
				ST_WALK_L: begin
					r_idx_q <= kid_rd[2*IDX_W-1:IDX_W];
					pc_q    <= pc;
					len_q   <= len_n;
					state_q <= ST_WALK_R;
				end
				ST_WALK_R: begin
					if (node_q == IDX_W'(n_q)) begin
						state_q <= ST_EMIT_RD;
					end else begin
						node_q  <= node_q - IDX_W'(1);
						state_q <= ST_WALK_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_CMP;
				end
				ST_EMIT_CMP: begin
					if (!match || m_free) begin
						if (match) begin
							m_sym_q   <= s_q;
							m_code_q  <= single_q ? '0 : nc_rd[CODE_W-1:0];
							m_len_q   <= single_q ? '0 : nc_rd[NCODE_W-1:CODE_W];
							m_drop_q  <= ovf_q;
							m_last_q  <= (emitted_q == n_q - CNT_W'(1));
							emitted_q <= emitted_q + CNT_W'(1);
						end
						if (match && (emitted_q == n_q - CNT_W'(1))) begin
							// run done: clear for the next load
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							live_q  <= '0;
							state_q <= ST_LOAD;
						end else begin
							if (last_pair) begin
								i_q <= '0;
								s_q <= s_q + 8'd1;
							end else begin
								i_q <= i_q + SIDX_W'(1);
							end
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[IDX_W-1:0];
	end

	assign s_tready = (state_q == ST_LOAD);
	assign m_tvalid = m_vld_q;
	assign m_tdata  = {4'b0, m_len_q, m_code_q, m_sym_q};
	assign m_tuser  = m_drop_q;
	assign m_tlast  = m_last_q;

`ifndef ASSERT_OFF
	a_take_has_min: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TAKE |-> best_vld)
		else $error("merge step without a live node");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> idx_q <= next_q)
		else $error("scan ran past the last node");
	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_CMP |-> emitted_q < n_q)
		else $error("more codes than leaves");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_CMP && match && m_vld_q && !m_tready |=> state_q == ST_EMIT_CMP)
		else $error("output overwritten while stalled");
`endif
endmodule
`default_nettype wire

[src/hcb_ram.sv]
// hcb_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module hcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

[src/hcb_min_unit.sv]
// hcb_min_unit: running minimum over streamed node weights, oldest wins ties.
// Depends on hcb_pkg.
`default_nettype none
module hcb_min_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       clr,
	input  wire hcb_pkg::hcb_sample_t       smp,
	input  wire logic [hcb_pkg::SUM_W-1:0]  wgt,
	output logic                            best_vld_q,
	output logic [hcb_pkg::IDX_W-1:0]       best_idx_q,
	output logic [hcb_pkg::SUM_W-1:0]       best_wgt_q
);
	logic take;

	// strict less-than: an earlier index keeps the slot on a tie
	assign take = smp.vld && smp.live && (!best_vld_q || (wgt < best_wgt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_q <= 1'b0;
		end else if (clr) begin
			best_vld_q <= 1'b0;
		end else if (take) begin
			best_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clr && take) begin
			best_idx_q <= smp.idx;
			best_wgt_q <= wgt;
		end
	end
endmodule
`default_nettype wire

[sim/tb_huffman_code_builder_unit.sv]
// tb_huffman_code_builder_unit: self-checking testbench for the Huffman code builder.
// Depends on hcb_pkg and huffman_code_builder_unit; drives random and directed symbol sets.
`timescale 1ns / 100ps
module tb_huffman_code_builder_unit;
	localparam int LIMIT = 3000000;
	localparam int TAIL  = 64;

	typedef struct packed {
		logic [7:0]  sym;
		logic [30:0] bits;
		logic [4:0]  len;
		logic        drop;
		logic        last;
	} code_t;

	// directed rows: item plus, where obvious, the single code it yields
	typedef struct {
		logic [7:0]  sym;
		logic [15:0] wt;
		logic        fin;
		logic        chk;
		code_t       exp;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	code_t       code_q[$];
	int          errors = 0;
	int          cycles = 0;
	int          items_sent = 0;
	int          runs = 0;
	int          codes_seen = 0;
	int          send_idle = 0;
	int          recv_idle = 0;

	// predictor state: loaded leaves of the current run
	logic [7:0]  leaf_sym[hcb_pkg::MAX_SYMBOLS];
	logic [20:0] leaf_wt[hcb_pkg::MAX_SYMBOLS];
	int          nload = 0;
	bit          ovf = 0;

	huffman_code_builder_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report(input string what);
		errors++;
		if (errors <= 40)
			$display("mismatch @%0d: %s", cycles, what);
	endtask

	// build tree over the loaded leaves and queue codes in symbol order
	task automatic predict_codes();
		logic [20:0] w[hcb_pkg::NODE_COUNT];
		bit          live[hcb_pkg::NODE_COUNT];
		int          lc[hcb_pkg::NODE_COUNT], rc[hcb_pkg::NODE_COUNT];
		logic [30:0] nc[hcb_pkg::NODE_COUNT];
		int          nl[hcb_pkg::NODE_COUNT];
		int          nxt, a, b, i, j, s, emitted;
		code_t       c;
		nxt = nload;
		for (i = 0; i < hcb_pkg::NODE_COUNT; i++) begin
			live[i] = (i < nload);
			w[i] = (i < nload) ? leaf_wt[i] : '0;
			nc[i] = '0;
			nl[i] = 0;
		end
		while (nxt < 2 * nload - 1) begin
			a = -1;
			for (j = 0; j < nxt; j++)
				if (live[j] && (a < 0 || w[j] < w[a])) a = j;
			live[a] = 0;
			b = -1;
			for (j = 0; j < nxt; j++)
				if (live[j] && (b < 0 || w[j] < w[b])) b = j;
			live[b] = 0;
			w[nxt] = w[a] + w[b];
			lc[nxt] = a;
			rc[nxt] = b;
			live[nxt] = 1;
			nxt++;
		end
		for (i = nxt - 1; i >= nload; i--) begin
			nc[lc[i]] = {nc[i][29:0], 1'b0};
			nc[rc[i]] = {nc[i][29:0], 1'b1};
			nl[lc[i]] = (nl[i] + 1 > 31) ? 31 : nl[i] + 1;
			nl[rc[i]] = nl[lc[i]];
		end
		emitted = 0;
		for (s = 0; s < 256; s++)
			for (i = 0; i < nload; i++)
				if (leaf_sym[i] == s[7:0]) begin
					c.sym = s[7:0];
					c.bits = nc[i];
					c.len = nl[i][4:0];
					c.drop = ovf;
					c.last = (emitted == nload - 1);
					code_q.push_back(c);
					emitted++;
				end
		nload = 0;
		ovf = 0;
	endtask

	task automatic load_item(input logic [7:0] sym, input logic [15:0] wt, input logic fin);
		if (nload < hcb_pkg::MAX_SYMBOLS) begin
			leaf_sym[nload] = sym;
			leaf_wt[nload] = {5'd0, wt};
			nload++;
		end else
			ovf = 1;
		if (fin) begin
			predict_codes();
			runs++;
		end
	endtask

	// one item through the input handshake, with random sender gaps;
	// tvalid stays up after the item, so back-to-back items keep it high throughout
	task automatic send_item(input logic [7:0] sym, input logic [15:0] wt, input logic fin);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {wt, sym};
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		load_item(sym, wt, fin);
		items_sent++;
	endtask

	// sender idle until every expected code is out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (code_q.size() != 0) @(posedge clk);
	endtask

	// receiver: random stalls, compares every accepted code
	always @(posedge clk) begin
		code_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.sym = m_tdata[7:0];
				got.bits = m_tdata[38:8];
				got.len = m_tdata[43:39];
				got.drop = m_tuser;
				got.last = m_tlast;
				codes_seen++;
				if (code_q.size() == 0)
					report($sformatf("unexpected code sym %0d", got.sym));
				else begin
					want = code_q.pop_front();
					if (got.sym !== want.sym)
						report($sformatf("symbol %0d want %0d", got.sym, want.sym));
					if (got.bits !== want.bits)
						report($sformatf("sym %0d bits %h want %h", want.sym, got.bits, want.bits));
					if (got.len !== want.len)
						report($sformatf("sym %0d len %0d want %0d", want.sym, got.len, want.len));
					if (got.drop !== want.drop)
						report($sformatf("sym %0d dropped %b want %b", want.sym, got.drop, want.drop));
					if (got.last !== want.last)
						report($sformatf("sym %0d last %b want %b", want.sym, got.last, want.last));
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// random run: mostly small sets, some large or overflowing ones
	task automatic random_run();
		int n, k, pick;
		logic [15:0] wt;
		pick = $urandom_range(99);
		if (pick < 8) n = hcb_pkg::MAX_SYMBOLS + $urandom_range(1, 4);
		else if (pick < 15) n = $urandom_range(17, hcb_pkg::MAX_SYMBOLS);
		else n = $urandom_range(1, 8);
		for (k = 0; k < n; k++) begin
			case ($urandom_range(3))
				0: wt = 16'($urandom_range(3));
				1: wt = 16'(16'hffff - $urandom_range(3));
				default: wt = 16'($urandom);
			endcase
			send_item(8'($urandom_range(255)), wt, k == n - 1);
		end
	endtask

	row_t rows[$];
	code_t expc;

	initial begin
		int r, p;
		// single symbol at the extremes: code length zero
		expc = '{sym: 8'd0, bits: '0, len: 5'd0, drop: 1'b0, last: 1'b1};
		rows.push_back('{8'd0, 16'd0, 1'b1, 1'b1, expc});
		expc.sym = 8'd255;
		rows.push_back('{8'd255, 16'hffff, 1'b1, 1'b1, expc});
		// two symbols, equal weights: first loaded gets branch 0
		rows.push_back('{8'd200, 16'd5, 1'b0, 1'b0, expc});
		rows.push_back('{8'd7, 16'd5, 1'b1, 1'b0, expc});
		// duplicate symbols, zero and full weights
		rows.push_back('{8'd9, 16'hffff, 1'b0, 1'b0, expc});
		rows.push_back('{8'd9, 16'd0, 1'b0, 1'b0, expc});
		rows.push_back('{8'd3, 16'h8000, 1'b0, 1'b0, expc});
		rows.push_back('{8'd128, 16'h7fff, 1'b1, 1'b0, expc});
		// skewed weights give long codes
		for (r = 0; r < 8; r++)
			rows.push_back('{8'(r * 17), 16'(1 << r), 1'b0, 1'b0, expc});
		rows.push_back('{8'hAA, 16'h5555, 1'b1, 1'b0, expc});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_item(rows[i].sym, rows[i].wt, rows[i].fin);
			if (rows[i].chk) begin
				// typed-in code must match what the checker expects at the output
				if (code_q.size() != 1 || code_q[$] !== rows[i].exp)
					report($sformatf("directed row %0d code", i));
				drain();
				@(posedge clk);
			end
		end
		drain();

		// overflow: full capacity plus drops, final item itself dropped
		for (r = 0; r < hcb_pkg::MAX_SYMBOLS + 2; r++)
			send_item(r[7:0], 16'(r + 1), r == hcb_pkg::MAX_SYMBOLS + 1);
		drain();

		for (p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle = 0;  recv_idle = 0;  end
				1: begin send_idle = 62; recv_idle = 0;  end
				2: begin send_idle = 0;  recv_idle = 62; end
				default: begin send_idle = 36; recv_idle = 36; end
			endcase
			while (items_sent < 52 + (p + 1) * 56) random_run();
			// hold the sender until every code of this phase is out
			drain();
		end

		drain();
		repeat (TAIL) @(posedge clk);
		$display("covered %0d items in %0d runs, %0d codes checked", items_sent, runs, codes_seen);
		$display("idle phases: none, sender, receiver, both; incl. overflow and one-leaf runs");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
